>>> hdl/mlr_pkg.sv
// ----------------------------------------------------------------------------
// mlr_pkg: shared types and constants for the modified Legendre block
// Field widths, default parameters, controller states, control structs.
// ----------------------------------------------------------------------------
package mlr_pkg;

   localparam int X_W       = 16;   // x, signed Q2.14
   localparam int X_FRAC    = 14;
   localparam int CNT_W     = 7;    // term count port
   localparam int IDX_W     = 6;    // term index port
   localparam int VAL_W     = 24;   // term value, signed

   localparam int MAX_TERMS_DEF = 64;
   localparam int FRAC_BITS_DEF = 20;

   // b_0 = (2^28 - x^2) / 2 lives in Q(2*X_FRAC+1) after the halving
   localparam int B0_FRAC   = 2 * X_FRAC + 1;

   // quotient bits produced by the divider once overflow is ruled out
   localparam int DIV_STEPS = VAL_W - 1;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_DIFF,
      ST_MAG,
      ST_SHIFT,
      ST_DIV_CHK,
      ST_DIV,
      ST_FIN
   } state_type;

   // controller -> datapath strobes
   typedef struct packed {
      logic load;
      logic mul_a;
      logic mul_b;
      logic diff;
      logic mag;
      logic shift;
      logic div_chk;
      logic div_step;
      logic fin;
   } cmd_type;

   // datapath -> controller flags
   typedef struct packed {
      logic cnt_zero;   // incoming word asks for no terms
      logic n_lt2;      // current degree is 0 or 1
      logic last;       // current degree is the final one of the run
      logic out_free;   // result register can take a new word
   } status_type;

endpackage

>>> hdl/mlr_ctrl.sv
// ----------------------------------------------------------------------------
// mlr_ctrl: sequencer for the modified Legendre recurrence
// Steps each term through multiply, difference, magnitude, divide or shift,
// and finish; owns the divider step count and the request stall.
// ----------------------------------------------------------------------------
module mlr_ctrl
   import mlr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   assign req_stall = reset || (state_ff != ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !status.cnt_zero) begin
               cmd.load = 1'b1;
               state_in = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            cmd.mul_a = 1'b1;
            state_in  = ST_MUL_B;
         end
         ST_MUL_B: begin
            cmd.mul_b = 1'b1;
            state_in  = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_MAG;
         end
         ST_MAG: begin
            cmd.mag  = 1'b1;
            state_in = status.n_lt2 ? ST_SHIFT : ST_DIV_CHK;
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            state_in  = ST_FIN;
         end
         ST_DIV_CHK: begin
            cmd.div_chk = 1'b1;
            div_cnt_in  = '0;
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // hold here until the result register can take the word
            if (status.out_free) begin
               cmd.fin  = 1'b1;
               state_in = status.last ? ST_IDLE : ST_MUL_A;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_div_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_cnt_ff < DIV_CNT_W'(DIV_STEPS)))
      else $error("divider step count out of range");

   a_accept_starts_run: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !status.cnt_zero) |=> (state_ff == ST_MUL_A))
      else $error("accepted word did not start a run");
`endif

endmodule

>>> hdl/mlr_datapath.sv
// ----------------------------------------------------------------------------
// mlr_datapath: arithmetic and storage for the modified Legendre recurrence
// Multipliers, numerator, sign/magnitude rounding, restoring divider,
// saturation, the two previous terms and the result register.
// ----------------------------------------------------------------------------
module mlr_datapath
   import mlr_pkg::*;
#(
   parameter int MAX_TERMS = MAX_TERMS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
)(
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic signed [X_W-1:0]   req_x_value,
   input  logic [CNT_W-1:0]        req_term_count,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [IDX_W-1:0]        rsp_term_index,
   output logic signed [VAL_W-1:0] rsp_term_value,
   output logic                    rsp_last_term
);

   localparam int NW = $clog2(MAX_TERMS + 1);     // degree / count width
   localparam int PW = X_W + VAL_W;               // x * b
   localparam int RW = NW + 1 + VAL_W;            // (n-1) * b_(n-2)
   localparam int LW = PW + NW + 2;               // (2n+1) * x * b_(n-1)
   localparam int DW = LW + 1;                    // numerator
   localparam int MW = DW;                        // magnitude plus half

   localparam int B0_RSH = (FRAC_BITS < B0_FRAC) ? B0_FRAC - FRAC_BITS : 0;
   localparam int B0_LSH = (FRAC_BITS > B0_FRAC) ? FRAC_BITS - B0_FRAC : 0;

   localparam logic [MW-1:0]        B0_HALF = MW'((1 << B0_RSH) >> 1);
   localparam logic [MW-1:0]        B1_HALF = MW'(1) << (X_FRAC - 1);
   localparam logic signed [DW-1:0] ONE_X2  = DW'(1) << (2 * X_FRAC);
   localparam logic [MW-1:0]        POS_LIM = MW'(2 ** (VAL_W - 1) - 1);
   localparam logic [MW-1:0]        NEG_LIM = MW'(2 ** (VAL_W - 1));

   logic signed [X_W-1:0]   x_ff, x_in;
   logic [NW-1:0]           cnt_ff, cnt_in;
   logic [NW-1:0]           n_ff, n_in;
   logic signed [VAL_W-1:0] b1_ff, b1_in;
   logic signed [VAL_W-1:0] b2_ff, b2_in;
   logic signed [PW-1:0]    p_ff, p_in;
   logic signed [RW-1:0]    rt_ff, rt_in;
   logic signed [LW-1:0]    left_ff, left_in;
   logic signed [DW-1:0]    num_ff, num_in;
   logic                    neg_ff, neg_in;
   logic [MW-1:0]           m_ff, m_in;
   logic [MW-1:0]           ds_ff, ds_in;
   logic [MW-1:0]           q_ff, q_in;
   logic                    over_ff, over_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]        rsp_index_ff, rsp_index_in;
   logic signed [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [NW-1:0]           cnt_clamp;
   logic [NW-1:0]           nm1;
   logic [NW:0]             n2;
   logic                    n_is0;
   logic                    n_is1;
   logic                    last;
   logic signed [VAL_W-1:0] mult_sel;
   logic [MW-1:0]           mag_w;
   logic [MW-1:0]           half_w;
   logic signed [VAL_W-1:0] q_lo;
   logic signed [VAL_W-1:0] val_w;

   assign cnt_clamp = (32'(req_term_count) > MAX_TERMS) ? NW'(MAX_TERMS)
                                                        : NW'(req_term_count);
   assign nm1   = n_ff - NW'(1);
   assign n2    = {1'b0, n_ff} + (NW + 1)'(2);
   assign n_is0 = (n_ff == '0);
   assign n_is1 = (n_ff == NW'(1));
   assign last  = (n_ff == cnt_ff - NW'(1));

   assign mult_sel = n_is0 ? VAL_W'(x_ff) : b1_ff;
   assign mag_w    = num_ff[DW-1] ? $unsigned(-num_ff) : $unsigned(num_ff);
   assign half_w   = n_is0 ? B0_HALF : (n_is1 ? B1_HALF : (MW'(n2) << (X_FRAC - 1)));

   // sign and saturate the rounded magnitude
   assign q_lo = q_ff[VAL_W-1:0];
   always_comb begin
      if (neg_ff) begin
         val_w = (over_ff || (q_ff > NEG_LIM)) ? VAL_MIN : -q_lo;
      end else begin
         val_w = (over_ff || (q_ff > POS_LIM)) ? VAL_MAX : q_lo;
      end
   end

   always_comb begin
      x_in         = x_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      p_in         = p_ff;
      rt_in        = rt_ff;
      left_in      = left_ff;
      num_in       = num_ff;
      neg_in       = neg_ff;
      m_in         = m_ff;
      ds_in        = ds_ff;
      q_in         = q_ff;
      over_in      = over_ff;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.load) begin
         x_in   = req_x_value;
         cnt_in = cnt_clamp;
         n_in   = '0;
         b1_in  = '0;
         b2_in  = '0;
      end
      if (cmd.mul_a) begin
         p_in  = x_ff * mult_sel;
         rt_in = $signed({1'b0, nm1}) * b2_ff;
      end
      if (cmd.mul_b) begin
         left_in = $signed({1'b0, n_ff, 1'b1}) * p_ff;
      end
      if (cmd.diff) begin
         if (n_is0) begin
            num_in = ONE_X2 - DW'(p_ff);
         end else if (n_is1) begin
            num_in = DW'(p_ff);
         end else begin
            num_in = DW'(left_ff) - (DW'(rt_ff) <<< X_FRAC);
         end
      end
      if (cmd.mag) begin
         // round half away from zero: add half the step to the magnitude
         neg_in = num_ff[DW-1];
         m_in   = mag_w + half_w;
         ds_in  = MW'(n2) << (X_FRAC + DIV_STEPS - 1);
      end
      if (cmd.shift) begin
         q_in    = n_is0 ? ((m_ff >> B0_RSH) << B0_LSH) : (m_ff >> X_FRAC);
         over_in = 1'b0;
      end
      if (cmd.div_chk) begin
         // quotient of 2^23 or more saturates either way
         over_in = (m_ff >= (MW'(n2) << (X_FRAC + DIV_STEPS)));
         q_in    = '0;
      end
      if (cmd.div_step) begin
         if (m_ff >= ds_ff) begin
            m_in = m_ff - ds_ff;
            q_in = {q_ff[MW-2:0], 1'b1};
         end else begin
            q_in = {q_ff[MW-2:0], 1'b0};
         end
         ds_in = ds_ff >> 1;
      end
      if (cmd.fin) begin
         b2_in        = b1_ff;
         b1_in        = val_w;
         n_in         = n_ff + NW'(1);
         rsp_index_in = IDX_W'(n_ff);
         rsp_value_in = val_w;
         rsp_last_in  = last;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      cnt_ff       <= cnt_in;
      n_ff         <= n_in;
      b1_ff        <= b1_in;
      b2_ff        <= b2_in;
      p_ff         <= p_in;
      rt_ff        <= rt_in;
      left_ff      <= left_in;
      num_ff       <= num_in;
      neg_ff       <= neg_in;
      m_ff         <= m_in;
      ds_ff        <= ds_in;
      q_ff         <= q_in;
      over_ff      <= over_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign status.cnt_zero = (req_term_count == '0);
   assign status.n_lt2    = n_is0 || n_is1;
   assign status.last     = last;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_term_index = rsp_index_ff;
   assign rsp_term_value = rsp_value_ff;
   assign rsp_last_term  = rsp_last_ff;

`ifndef SYNTHESIS
   a_fin_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |-> (!rsp_valid_ff || !rsp_stall))
      else $error("finished term would overwrite a waiting word");

   a_degree_in_run: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_a |-> (n_ff < cnt_ff))
      else $error("degree ran past the term count");
`endif

endmodule

>>> hdl/modified_legendre_recurrence_top.sv
// ----------------------------------------------------------------------------
// modified_legendre_recurrence_top: modified Legendre upward recurrence
// Takes x (Q2.14) and a term count, returns b_0 .. b_(count-1) in Q4.20,
// count clamped to MAX_TERMS, saturated to 24 bits, final word flagged.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | dir | word
//  --------+-----------------------------------------+-----+-------------------
//  req     | req_valid req_stall req_x_value         | in  | one x and count
//          | req_term_count                          |     |
//  rsp     | rsp_valid rsp_stall rsp_term_index      | out | one term b_n
//          | rsp_term_value rsp_last_term            |     |
//
//  Steps: the controller walks each term through a fixed sequence.
//  Degrees 0 and 1 go through two multiplies, difference, rounding, shift
//  and finish. Degrees 2 and up replace the shift with an overflow check
//  and the restoring divider by (n+2)*2^14, which retires one quotient bit
//  a cycle for 23 bits. Reset (synchronous, active high) clears the
//  controller and result valid. A stalled result word holds the next term
//  in its finish step; the last word may wait while the next request word
//  is already taken.
//
module modified_legendre_recurrence_top
   import mlr_pkg::*;
#(
   parameter int MAX_TERMS = MAX_TERMS_DEF,   // count clamp
   parameter int FRAC_BITS = FRAC_BITS_DEF    // fraction bits of term_value
)(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [X_W-1:0]   req_x_value,
   input  logic [CNT_W-1:0]        req_term_count,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [IDX_W-1:0]        rsp_term_index,
   output logic signed [VAL_W-1:0] rsp_term_value,
   output logic                    rsp_last_term
);

   cmd_type    cmd;
   status_type status;

   // sequencer: one term at a time, request stalled while a run is active
   mlr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic, previous terms, divider and result register
   mlr_datapath #(
      .MAX_TERMS (MAX_TERMS),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_x_value    (req_x_value),
      .req_term_count (req_term_count),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_term_index (rsp_term_index),
      .rsp_term_value (rsp_term_value),
      .rsp_last_term  (rsp_last_term)
   );

endmodule

>>> verif/tb_modified_legendre_recurrence_top.sv
// ----------------------------------------------------------------------------
// tb_modified_legendre_recurrence_top: testbench for the modified Legendre block
// Sends (x, term count) words and checks every returned term b_n against a
// bit-exact fixed-point predictor: degree, saturated value and last flag.
// ----------------------------------------------------------------------------
module tb_modified_legendre_recurrence_top;
   import mlr_pkg::*;

   localparam int CLK_HALF      = 5;
   localparam int RESET_CYCLES  = 12;
   // worst case: ~130 words x 64 terms with long stalls, several times over
   localparam int CYCLE_LIMIT   = 3_000_000;
   // after the drain; covers a zero-count word and stray output
   localparam int SETTLE_CYCLES = 120;

   // one expected result word
   typedef struct {
      logic [IDX_W-1:0]        degree;
      logic signed [VAL_W-1:0] value;
      logic                    is_last;
   } term_word_type;

   logic                    clock          = 1'b0;
   logic                    reset          = 1'b1;
   logic                    req_valid      = 1'b0;
   logic                    req_stall;
   logic signed [X_W-1:0]   req_x_value    = '0;
   logic [CNT_W-1:0]        req_term_count = '0;
   logic                    rsp_valid;
   logic                    rsp_stall      = 1'b0;
   logic [IDX_W-1:0]        rsp_term_index;
   logic signed [VAL_W-1:0] rsp_term_value;
   logic                    rsp_last_term;

   term_word_type pending_terms[$];   // predicted terms not yet returned
   int         fail_count   = 0;
   int         cycle_count  = 0;
   int         send_idle_pct = 0;  // chance per cycle that the sender holds off
   int         rsp_stall_pct = 0;  // chance per cycle that the receiver stalls

   modified_legendre_recurrence_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_x_value    (req_x_value),
      .req_term_count (req_term_count),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_term_index (rsp_term_index),
      .rsp_term_value (rsp_term_value),
      .rsp_last_term  (rsp_last_term)
   );

   always #CLK_HALF clock = ~clock;

   // ---------------------------------------------------------------------
   // Fixed-point helpers. All rounding is to nearest, ties away from zero.
   // ---------------------------------------------------------------------

   // v * 2^e; for e < 0 the dropped bits are rounded
   function automatic longint pow2_round(longint v, int e);
      longint unsigned mag;
      bit              neg;
      neg = (v < 0);
      mag = neg ? -v : v;
      if (e >= 0)
         mag = mag << e;
      else
         mag = (mag + (64'd1 << (-e - 1))) >> (-e);
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   // v / d, d > 0
   function automatic longint div_nearest(longint v, longint d);
      longint unsigned mag;
      longint unsigned div;
      bit              neg;
      neg = (v < 0);
      mag = neg ? -v : v;
      div = d;
      mag = (mag + div / 2) / div;
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic logic signed [VAL_W-1:0] saturate_term(longint v);
      if (v > longint'(VAL_MAX)) return VAL_MAX;
      if (v < longint'(VAL_MIN)) return VAL_MIN;
      return v[VAL_W-1:0];
   endfunction

   // Upward recurrence for one accepted word; queues b_0 .. b_(terms-1).
   // Saturated values feed the later terms, as in the block.
   function automatic void predict_terms(logic signed [X_W-1:0] x,
                                         logic [CNT_W-1:0] count);
      int                      terms;
      longint                  xs;
      longint                  num;
      logic signed [VAL_W-1:0] newest;
      logic signed [VAL_W-1:0] older;
      logic signed [VAL_W-1:0] v;
      term_word_type           w;
      terms  = (count > MAX_TERMS_DEF) ? MAX_TERMS_DEF : count;
      xs     = x;
      newest = '0;
      older  = '0;
      if (terms == 0) return;   // nothing produced
      for (int n = 0; n < terms; n++) begin
         if (n == 0) begin
            // 2^28 - x^2 is exact in Q28; halve and round once
            v = saturate_term(pow2_round((64'sd1 << 28) - xs * xs, FRAC_BITS_DEF - 29));
         end else if (n == 1) begin
            v = saturate_term(pow2_round(xs * longint'(newest), -X_FRAC));
         end else begin
            num = longint'(2 * n + 1) * xs * longint'(newest)
                - longint'(n - 1) * longint'(older) * 16384;
            v = saturate_term(div_nearest(num, longint'(n + 2) << X_FRAC));
         end
         older     = newest;
         newest    = v;
         w.degree  = IDX_W'(n);
         w.value   = v;
         w.is_last = (n == terms - 1);
         pending_terms.push_back(w);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus plumbing
   // ---------------------------------------------------------------------

   // Sends one word; call at a rising edge, returns at the accepting edge.
   // Valid is left high so back-to-back words need no idle gap.
   task automatic send_word(input logic signed [X_W-1:0] x,
                            input logic [CNT_W-1:0] terms);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_x_value    <= x;
      req_term_count <= terms;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predict_terms(x, terms);
   endtask

   // Sender holds off until every predicted term has come back.
   // Always moves at least one edge so valid is never lowered and raised
   // in the same step.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_terms.size() != 0);
   endtask

   task automatic set_idling(input int send_pct, input int stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // Mostly the natural domain |x| <= 1, some full-range samples
   // (saturation) and some at the corners.
   function automatic logic signed [X_W-1:0] pick_sample();
      int r;
      int s;
      r = $urandom_range(0, 9);
      if (r < 6) begin
         s = $urandom_range(0, 32768);
         s = s - 16384;
      end else if (r < 9) begin
         s = $urandom;
      end else begin
         case ($urandom_range(0, 3))
            0:       s = 32767;
            1:       s = -32768;
            2:       s = 16384;
            default: s = -16384;
         endcase
      end
      return s[X_W-1:0];
   endfunction

   // Short runs dominate to keep the run time down; a few hit the clamp.
   function automatic logic [CNT_W-1:0] pick_term_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)  return '0;
      if (r < 70) return CNT_W'($urandom_range(1, 8));
      if (r < 90) return CNT_W'($urandom_range(9, 24));
      if (r < 97) return CNT_W'($urandom_range(25, MAX_TERMS_DEF));
      return CNT_W'($urandom_range(MAX_TERMS_DEF + 1, (1 << CNT_W) - 1));
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // x at zero, +-1, the range ends and small values; counts 1..64
   task automatic test_sample_extremes();
      send_word(16'sd0,      7'd1);
      send_word(16'sd16384,  7'd2);
      send_word(-16'sd16384, 7'd3);
      send_word(16'sd32767,  7'd4);
      send_word(-16'sd32768, 7'd5);
      send_word(16'sd8192,   7'd64);
      send_word(-16'sd1,     7'd7);
      send_word(16'sd1,      7'd12);
   endtask

   // zero count must produce nothing; a normal word after it still works
   task automatic test_zero_count();
      send_word(16'sd1234,   7'd0);
      send_word(-16'sd32768, 7'd0);
      send_word(16'sd32767,  7'd0);
      send_word(16'sd5,      7'd1);
   endtask

   // counts above the maximum are clamped to a full run
   task automatic test_count_clamp();
      send_word(16'sd12000, 7'd65);
      send_word(-16'sd7000, 7'd127);
      send_word(16'sd300,   7'd100);
   endtask

   // |x| > 1: values hit the limits and saturated terms feed the recurrence
   task automatic test_saturation();
      send_word(16'sd32767,  7'd24);
      send_word(-16'sd32768, 7'd24);
      send_word(-16'sd23000, 7'd16);
      send_word(16'sd26000,  7'd9);
   endtask

   // sender pauses until the block has fully drained, then resumes
   task automatic test_drain_pause();
      send_word(pick_sample(), 7'd3);
      send_word(pick_sample(), 7'd5);
      wait_for_drain();
      send_word(pick_sample(), 7'd2);
   endtask

   task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                      input int words);
      set_idling(send_pct, stall_pct);
      repeat (words) send_word(pick_sample(), pick_term_count());
   endtask

   // ---------------------------------------------------------------------
   // Receiver: random stall, one decision per cycle
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   task automatic report_mismatch(input string field, input longint want,
                                  input longint got);
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d",
               $time, field, want, got);
   endtask

   // ---------------------------------------------------------------------
   // Result checker: every accepted word against the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      term_word_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_terms.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected word, expected none, actual degree %0d value %0d",
                     $time, rsp_term_index, rsp_term_value);
         end else begin
            want = pending_terms.pop_front();
            if (rsp_term_index !== want.degree)
               report_mismatch("term_index", want.degree, rsp_term_index);
            if (rsp_term_value !== want.value)
               report_mismatch("term_value", want.value, rsp_term_value);
            if (rsp_last_term !== want.is_last)
               report_mismatch("last_term", want.is_last, rsp_last_term);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence: reset, directed tests, then three random phases
   // (receiver-heavy idling, sender-heavy idling, none).
   // ---------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      set_idling(36, 61);
      test_sample_extremes();
      test_zero_count();
      test_count_clamp();
      test_saturation();
      test_drain_pause();
      test_random_traffic(36, 61, 36);
      test_random_traffic(61, 36, 36);
      test_random_traffic(0, 0, 36);
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
